>>> rtl/fdsfb_pkg.sv
package fdsfb_pkg;

    // Request kinds carried on the input tuser field.
    localparam logic [1:0] OP_NUMBER = 2'd0;
    localparam logic [1:0] OP_TIME   = 2'd1;
    localparam logic [1:0] OP_DIGIT  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Controller command bytes and the colon segment.
    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h88;
    localparam logic [7:0] COLON_BIT = 8'h80;

    // Number shown when a time request carries an hour or minute out of range.
    localparam logic [15:0] TIME_ERROR = 16'd9999;

    // Four segment bytes of one request, units position first.
    typedef struct packed {
        logic [7:0] seg3;
        logic [7:0] seg2;
        logic [7:0] seg1;
        logic [7:0] seg0;
    } seg_frame_t;

    // Segment pattern of one decimal digit for the reversed display.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h74;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h6F;
            4'd7:    code = 8'h38;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7C;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/fdsfb_digit_pipe.sv
module fdsfb_digit_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_op,
    input  logic [15:0]            in_value,
    input  logic [5:0]             in_hour,
    input  logic [6:0]             in_minute,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fdsfb_pkg::seg_frame_t  out_frame
);
    import fdsfb_pkg::*;

    // Stage handshake: a stage moves when it is empty or the next one moves.
    logic a_adv, b_adv, c_adv, d_adv, e_adv;
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;

    assign e_adv    = !e_vld_reg || out_ready;
    assign d_adv    = !d_vld_reg || e_adv;
    assign c_adv    = !c_vld_reg || d_adv;
    assign b_adv    = !b_vld_reg || c_adv;
    assign a_adv    = !a_vld_reg || b_adv;
    assign in_ready = a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_adv) a_vld_reg <= in_valid;
            if (b_adv) b_vld_reg <= a_vld_reg;
            if (c_adv) c_vld_reg <= b_vld_reg;
            if (d_adv) d_vld_reg <= c_vld_reg;
            if (e_adv) e_vld_reg <= d_vld_reg;
        end
    end

    // Stage A: reduce every request to a number plus blanking and colon flags.
    // A valid time becomes hour * 100 + minute so the common digit split applies.
    logic [15:0] a_num_next, a_num_reg;
    logic [3:0]  a_blank_next, a_blank_reg;
    logic        a_colon_next, a_colon_reg;
    logic        time_ok;
    logic [15:0] time_num;

    assign time_ok  = (in_hour <= 6'd23) && (in_minute <= 7'd59);
    assign time_num = 16'(in_hour) * 16'd100 + 16'(in_minute);

    always_comb
    begin
        a_num_next   = in_value;
        a_blank_next = 4'b0000;
        a_colon_next = 1'b0;
        case (in_op)
            OP_NUMBER:
            begin
                a_num_next = in_value;
            end
            OP_TIME:
            begin
                a_num_next   = time_ok ? time_num : TIME_ERROR;
                a_colon_next = time_ok;
            end
            OP_DIGIT:
            begin
                a_num_next   = (in_value > 16'd9) ? 16'd9 : in_value;
                a_blank_next = 4'b1110;
            end
            default:
            begin
                a_num_next   = 16'd0;
                a_blank_next = 4'b1111;
            end
        endcase
    end

    // Stage B: hundreds and thousands quotients by reciprocal multiplication.
    logic [15:0] b_num_next, b_num_reg;
    logic [9:0]  b_q100_next, b_q100_reg;
    logic [6:0]  b_q1000_next, b_q1000_reg;
    logic [3:0]  b_blank_reg;
    logic        b_colon_reg;
    logic [32:0] prod_q100;
    logic [32:0] prod_q1000;

    assign prod_q100    = 33'(a_num_reg) * 33'd83887;
    assign prod_q1000   = 33'(a_num_reg) * 33'd67109;
    assign b_num_next   = a_num_reg;
    assign b_q100_next  = prod_q100[32:23];
    assign b_q1000_next = prod_q1000[32:26];

    // Stage C: remainder below one hundred, and thousands divided by ten.
    logic [6:0]  c_r100_next, c_r100_reg;
    logic [9:0]  c_q100_reg;
    logic [6:0]  c_q1000_reg;
    logic [2:0]  c_v_next, c_v_reg;
    logic [3:0]  c_blank_reg;
    logic        c_colon_reg;
    logic [15:0] q100_times;
    logic [10:0] prod_v;

    assign q100_times  = 16'(b_q100_reg) * 16'd100;
    assign c_r100_next = 7'(b_num_reg - q100_times);
    assign prod_v      = 11'(b_q1000_reg) * 11'd13;
    assign c_v_next    = prod_v[9:7];

    // Stage D: tens quotients and the thousands digit.
    logic [3:0]  d_u1_next, d_u1_reg;
    logic [6:0]  d_t_next, d_t_reg;
    logic [3:0]  d_d3_next, d_d3_reg;
    logic [6:0]  d_r100_reg;
    logic [9:0]  d_q100_reg;
    logic [3:0]  d_blank_reg;
    logic        d_colon_reg;
    logic [14:0] prod_u1;
    logic [17:0] prod_t;
    logic [6:0]  v_times;

    assign prod_u1   = 15'(c_r100_reg) * 15'd205;
    assign prod_t    = 18'(c_q100_reg) * 18'd205;
    assign d_u1_next = prod_u1[14:11];
    assign d_t_next  = prod_t[17:11];
    assign v_times   = {1'b0, c_v_reg, 3'b000} + {3'b000, c_v_reg, 1'b0};
    assign d_d3_next = 4'(c_q1000_reg - v_times);

    // Stage E: remaining digits and the segment patterns.
    seg_frame_t  e_frame_next, e_frame_reg;
    logic [6:0]  u1_times;
    logic [9:0]  t_times;
    logic [3:0]  dig0, dig2;
    logic [7:0]  colon_seg;

    assign u1_times  = {d_u1_reg, 3'b000} + {2'b00, d_u1_reg, 1'b0};
    assign t_times   = {d_t_reg, 3'b000} + {2'b00, d_t_reg, 1'b0};
    assign dig0      = 4'(d_r100_reg - u1_times);
    assign dig2      = 4'(d_q100_reg - t_times);
    assign colon_seg = d_colon_reg ? COLON_BIT : 8'h00;

    always_comb
    begin
        e_frame_next.seg0 = d_blank_reg[0] ? 8'h00 : seg_code(dig0);
        e_frame_next.seg1 = d_blank_reg[1] ? 8'h00 : (seg_code(d_u1_reg) | colon_seg);
        e_frame_next.seg2 = d_blank_reg[2] ? 8'h00 : seg_code(dig2);
        e_frame_next.seg3 = d_blank_reg[3] ? 8'h00 : seg_code(d_d3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_num_reg   <= a_num_next;
            a_blank_reg <= a_blank_next;
            a_colon_reg <= a_colon_next;
        end
        if (b_adv)
        begin
            b_num_reg   <= b_num_next;
            b_q100_reg  <= b_q100_next;
            b_q1000_reg <= b_q1000_next;
            b_blank_reg <= a_blank_reg;
            b_colon_reg <= a_colon_reg;
        end
        if (c_adv)
        begin
            c_r100_reg  <= c_r100_next;
            c_q100_reg  <= b_q100_reg;
            c_q1000_reg <= b_q1000_reg;
            c_v_reg     <= c_v_next;
            c_blank_reg <= b_blank_reg;
            c_colon_reg <= b_colon_reg;
        end
        if (d_adv)
        begin
            d_u1_reg    <= d_u1_next;
            d_t_reg     <= d_t_next;
            d_d3_reg    <= d_d3_next;
            d_r100_reg  <= c_r100_reg;
            d_q100_reg  <= c_q100_reg;
            d_blank_reg <= c_blank_reg;
            d_colon_reg <= c_colon_reg;
        end
        if (e_adv)
        begin
            e_frame_reg <= e_frame_next;
        end
    end

    assign out_valid = e_vld_reg;
    assign out_frame = e_frame_reg;

endmodule

>>> rtl/four_digit_segment_frame_builder.sv
// Builds the command byte stream for a four-digit segment display controller.
// Each request on the slave stream (a number, an hour:minute time, a single
// compartment digit, or a clear) becomes seven bytes on the master stream:
// the data command alone in its own frame, the address command followed by
// four segment bytes (units digit first, for a display mounted reversed),
// and the display control command carrying the brightness, again framed on
// its own. A request passes through the registered stages A to E of the
// digit pipeline, and the byte sequencer then sends one byte per cycle while
// the receiver is ready, sending the seven bytes of each request in turn. The
// pipeline keeps accepting requests while the sequencer is still sending the
// bytes of an earlier one. The brightness register resets to 7 and is written
// through the configuration channel, which is always ready.
module four_digit_segment_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value [15:0], hour [21:16], minute [28:22], zero [31:29]
    input  logic [1:0]  s_tuser,    // op [1:0]
    // Byte stream towards the serial bus engine.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // bus_byte [7:0]
    output logic [1:0]  m_tuser,    // frame_start [0], frame_end [1]
    output logic        m_tlast,
    // Brightness register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import fdsfb_pkg::*;

    // Position of the byte being sent within the seven-byte request.
    localparam logic [2:0] BYTE_DATA = 3'd0;
    localparam logic [2:0] BYTE_ADDR = 3'd1;
    localparam logic [2:0] BYTE_SEG0 = 3'd2;
    localparam logic [2:0] BYTE_SEG1 = 3'd3;
    localparam logic [2:0] BYTE_SEG2 = 3'd4;
    localparam logic [2:0] BYTE_SEG3 = 3'd5;
    localparam logic [2:0] BYTE_CTRL = 3'd6;

    logic       pipe_valid;
    logic       pipe_ready;
    seg_frame_t pipe_frame;

    fdsfb_digit_pipe u_digit_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_value  (s_tdata[15:0]),
        .in_hour   (s_tdata[21:16]),
        .in_minute (s_tdata[28:22]),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_frame (pipe_frame)
    );

    // Brightness register. Writes must arrive only while the block is idle, which
    // the block does not enforce; the control byte reads it at the moment it is sent.
    logic [2:0] bright_reg, bright_next;

    assign cfg_ready   = 1'b1;
    assign bright_next = cfg_valid ? cfg_data : bright_reg;

    // Byte sequencer. It holds one frame of segment bytes and walks through
    // the seven bytes. A new frame is loaded as soon as the last byte of the
    // current one is taken, so consecutive requests leave no gap on the bus.
    seg_frame_t frame_reg, frame_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       busy_reg, busy_next;
    logic       byte_take;
    logic       last_take;
    logic       load;

    assign byte_take  = busy_reg && m_tready;
    assign last_take  = byte_take && (cnt_reg == BYTE_CTRL);
    assign pipe_ready = !busy_reg || last_take;
    assign load       = pipe_valid && pipe_ready;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            frame_next = pipe_frame;
            cnt_next   = BYTE_DATA;
            busy_next  = 1'b1;
        end
        else if (last_take)
        begin
            busy_next = 1'b0;
        end
        else if (byte_take)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= BYTE_DATA;
            busy_reg   <= 1'b0;
            bright_reg <= 3'd7;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            bright_reg <= bright_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    // Byte contents and framing marks for the current position.
    logic [7:0] byte_out;
    logic       start_out;
    logic       end_out;

    always_comb
    begin
        byte_out  = 8'h00;
        start_out = 1'b0;
        end_out   = 1'b0;
        case (cnt_reg)
            BYTE_DATA:
            begin
                byte_out  = CMD_DATA;
                start_out = 1'b1;
                end_out   = 1'b1;
            end
            BYTE_ADDR:
            begin
                byte_out  = CMD_ADDR;
                start_out = 1'b1;
            end
            BYTE_SEG0: byte_out = frame_reg.seg0;
            BYTE_SEG1: byte_out = frame_reg.seg1;
            BYTE_SEG2: byte_out = frame_reg.seg2;
            BYTE_SEG3:
            begin
                byte_out = frame_reg.seg3;
                end_out  = 1'b1;
            end
            BYTE_CTRL:
            begin
                byte_out  = CMD_CTRL | {5'b00000, bright_reg};
                start_out = 1'b1;
                end_out   = 1'b1;
            end
            default: byte_out = 8'h00;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = byte_out;
    assign m_tuser  = {end_out, start_out};
    assign m_tlast  = (cnt_reg == BYTE_CTRL);

`ifndef SYNTHESIS
    // The byte counter never runs past the control byte.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= BYTE_CTRL)
        else $error("byte counter out of range");

    // After the last byte of a request, the next byte shown opens a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata == CMD_DATA))
        else $error("request did not restart with the data command");

    // The last byte is always the framed display control command.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[7:3] == CMD_CTRL[7:3] && m_tuser == 2'b11))
        else $error("last byte is not the display control command");

    // A frame is taken from the pipeline only when the sequencer is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || last_take))
        else $error("frame loaded while the sequencer was busy");
`endif

endmodule

>>> bench/tb_four_digit_segment_frame_builder.sv
`timescale 1ns / 1ps

module tb_four_digit_segment_frame_builder;
    import fdsfb_pkg::*;

    // Segment patterns of the digits 0 to 9, digit 0 in the lowest byte.
    localparam logic [79:0] DIGIT_PATTERNS = {
        8'h7C, 8'h7F, 8'h38, 8'h6F, 8'h6D, 8'h74, 8'h79, 8'h5B, 8'h30, 8'h3F
    };

    // Cycles the receiver holds off in the long stall, well beyond what the
    // digit pipeline and the byte sequencer can absorb.
    localparam int HOLD_OFF_CYCLES = 80;

    // Receiver behaviors, switched at random by the receiver itself.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_t;

    // One byte expected on the master stream.
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       is_last;
    } bus_word_t;

    // One row of the directed table. Where typed is set, segs holds the
    // segment bytes written out by hand; elsewhere the predictor supplies them.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] value;
        logic [5:0]  hour;
        logic [6:0]  minute;
        logic        typed;
        seg_frame_t  segs;
    } request_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // value [15:0], hour [21:16], minute [28:22], zero [31:29]
    logic [1:0]  s_tuser;     // op [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // bus_byte [7:0]
    logic [1:0]  m_tuser;     // frame_start [0], frame_end [1]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;

    // Bytes still owed by the block, oldest first.
    bus_word_t    pending_bytes [$];
    request_row_t directed_rows [$];

    // The testbench's own copy of the brightness register.
    logic [2:0]  bright_level;
    int          error_count;
    bit          hold_off_req;
    ready_mode_t ready_mode;

    four_digit_segment_frame_builder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Guard against a hung block. The slowest legal run needs well under a
    // tenth of this time.
    initial
    begin
        #5_000_000;
        $display("four_digit_segment_frame_builder: mismatch");
        $finish;
    end

    // Four segment bytes of a number, units first. Every digit is taken
    // modulo 10, so the thousands digit of a five-digit number wraps.
    function automatic seg_frame_t number_segments(input int n);
        seg_frame_t segs;
        segs.seg0 = DIGIT_PATTERNS[8 * (n % 10) +: 8];
        segs.seg1 = DIGIT_PATTERNS[8 * ((n / 10) % 10) +: 8];
        segs.seg2 = DIGIT_PATTERNS[8 * ((n / 100) % 10) +: 8];
        segs.seg3 = DIGIT_PATTERNS[8 * ((n / 1000) % 10) +: 8];
        return segs;
    endfunction

    // Segment bytes that one request puts on the display.
    function automatic seg_frame_t predict_segments(input logic [1:0] op,
                                                    input logic [15:0] value,
                                                    input logic [5:0] hour,
                                                    input logic [6:0] minute);
        seg_frame_t segs;
        int         digit;
        segs = '0;
        case (op)
            OP_NUMBER:
            begin
                segs = number_segments(int'(value));
            end
            OP_TIME:
            begin
                // An hour or minute out of range shows 9999 with no colon.
                if (hour > 6'd23 || minute > 7'd59)
                begin
                    segs = number_segments(int'(TIME_ERROR));
                end
                else
                begin
                    segs.seg0 = DIGIT_PATTERNS[8 * (int'(minute) % 10) +: 8];
                    segs.seg1 = DIGIT_PATTERNS[8 * (int'(minute) / 10) +: 8] | COLON_BIT;
                    segs.seg2 = DIGIT_PATTERNS[8 * (int'(hour) % 10) +: 8];
                    segs.seg3 = DIGIT_PATTERNS[8 * (int'(hour) / 10) +: 8];
                end
            end
            OP_DIGIT:
            begin
                // The compartment digit saturates at 9 and sits in the
                // rightmost position alone.
                digit = (value > 16'd9) ? 9 : int'(value);
                segs.seg0 = DIGIT_PATTERNS[8 * digit +: 8];
            end
            default:
            begin
                segs = '0;
            end
        endcase
        return segs;
    endfunction

    // Queues the seven bytes of one request: the data command framed alone,
    // the address command opening a frame with the four segment bytes, and
    // the control command with the current brightness framed alone.
    function automatic void push_frame(input seg_frame_t segs);
        pending_bytes.push_back('{CMD_DATA, 1'b1, 1'b1, 1'b0});
        pending_bytes.push_back('{CMD_ADDR, 1'b1, 1'b0, 1'b0});
        pending_bytes.push_back('{segs.seg0, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back('{segs.seg1, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back('{segs.seg2, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back('{segs.seg3, 1'b0, 1'b1, 1'b0});
        pending_bytes.push_back('{CMD_CTRL | {5'b00000, bright_level}, 1'b1, 1'b1, 1'b1});
    endfunction

    function automatic void report_field(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    endfunction

    // Offers one request from the falling edge on and holds it until the
    // block takes it. The expectation is queued at the accepting edge, so the
    // brightness in force at that moment is the one predicted.
    task automatic offer_request(input request_row_t row);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, row.minute, row.hour, row.value};
        s_tuser  = row.op;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        push_frame(row.typed ? row.segs : predict_segments(row.op, row.value, row.hour,
                                                           row.minute));
    endtask

    // Idle cycles on the request side. The data lines carry noise meanwhile.
    task automatic sender_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = {3'b000, 29'($urandom)};
            s_tuser  = 2'($urandom);
        end
    endtask

    // Stops offering and waits until every expected byte has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Brightness is only changed while the block is idle.
    task automatic write_brightness(input logic [2:0] level);
        wait_for_drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = level;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        bright_level = level;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A random request. Most time requests are well formed, most compartment
    // values sit near the clamp point, and the unused fields carry noise.
    function automatic request_row_t random_request();
        request_row_t row;
        int           pick;
        row.typed  = 1'b0;
        row.segs   = '0;
        row.value  = 16'($urandom);
        row.hour   = 6'($urandom);
        row.minute = 7'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            row.op = OP_NUMBER;
            if ($urandom_range(0, 3) == 0)
            begin
                row.value = 16'($urandom_range(0, 9999));
            end
        end
        else if (pick < 65)
        begin
            row.op = OP_TIME;
            if ($urandom_range(0, 4) != 0)
            begin
                row.hour   = 6'($urandom_range(0, 23));
                row.minute = 7'($urandom_range(0, 59));
            end
        end
        else if (pick < 90)
        begin
            row.op = OP_DIGIT;
            if ($urandom_range(0, 2) != 0)
            begin
                row.value = 16'($urandom_range(0, 12));
            end
        end
        else
        begin
            row.op = OP_CLEAR;
        end
        return row;
    endfunction

    // Random requests in bursts. With gaps enabled, the idle stretches range
    // over every phase of the seven-byte sequence.
    task automatic run_random_phase(input int count, input bit with_gaps);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                offer_request(random_request());
                sent++;
            end
            if (with_gaps && $urandom_range(0, 3) != 0)
            begin
                sender_gap($urandom_range(1, 9));
            end
        end
    endtask

    // Receiver. It switches among its own ready patterns and serves the long
    // hold-off when the request side asks for one.
    initial
    begin
        int mode_cycles;
        int pattern_phase;
        m_tready      = 1'b0;
        mode_cycles   = 0;
        pattern_phase = 0;
        ready_mode    = READY_ALWAYS;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1)
                begin
                    @(negedge clk);
                end
                hold_off_req = 1'b0;
            end
            else
            begin
                if (mode_cycles == 0)
                begin
                    ready_mode  = ready_mode_t'($urandom_range(0, 3));
                    mode_cycles = $urandom_range(40, 200);
                end
                mode_cycles--;
                pattern_phase = (pattern_phase + 1) % 5;
                case (ready_mode)
                    READY_ALWAYS:  m_tready = 1'b1;
                    READY_RANDOM:  m_tready = ($urandom_range(0, 1) == 1);
                    READY_PATTERN: m_tready = (pattern_phase >= 2);
                    READY_SPARSE:  m_tready = ($urandom_range(0, 3) == 0);
                    default:       m_tready = 1'b1;
                endcase
            end
        end
    end

    // Every byte taken from the master stream is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        bus_word_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: byte 0x%0h expected none actual one", $time, m_tdata);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.bus_byte)
                begin
                    report_field("bus_byte", want.bus_byte, m_tdata);
                end
                if (m_tuser[0] !== want.frame_start)
                begin
                    report_field("frame_start", want.frame_start, m_tuser[0]);
                end
                if (m_tuser[1] !== want.frame_end)
                begin
                    report_field("frame_end", want.frame_end, m_tuser[1]);
                end
                if (m_tlast !== want.is_last)
                begin
                    report_field("last", want.is_last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_NUMBER;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        bright_level = 3'd7;
        error_count  = 0;

        // Directed table. Hand-written segment bytes cover the extremes, the
        // out-of-range times, the compartment clamp and the clear request.
        directed_rows.push_back('{OP_NUMBER, 16'd0,     6'd0,  7'd0,   1'b1, 32'h3F3F3F3F});
        directed_rows.push_back('{OP_NUMBER, 16'hFFFF,  6'h3F, 7'h7F,  1'b1, 32'h6D6D796D});
        directed_rows.push_back('{OP_NUMBER, 16'd9999,  6'd0,  7'd0,   1'b1, 32'h7C7C7C7C});
        directed_rows.push_back('{OP_NUMBER, 16'd1234,  6'd5,  7'd9,   1'b0, 32'h0});
        directed_rows.push_back('{OP_NUMBER, 16'd12345, 6'd0,  7'd0,   1'b0, 32'h0});
        directed_rows.push_back('{OP_NUMBER, 16'd1000,  6'h2A, 7'h55,  1'b0, 32'h0});
        directed_rows.push_back('{OP_TIME,   16'd0,     6'd0,  7'd0,   1'b1, 32'h3F3FBF3F});
        directed_rows.push_back('{OP_TIME,   16'hFFFF,  6'd23, 7'd59,  1'b1, 32'h5B79ED7C});
        directed_rows.push_back('{OP_TIME,   16'd0,     6'd24, 7'd0,   1'b1, 32'h7C7C7C7C});
        directed_rows.push_back('{OP_TIME,   16'd0,     6'd12, 7'd60,  1'b1, 32'h7C7C7C7C});
        directed_rows.push_back('{OP_TIME,   16'd0,     6'd23, 7'd60,  1'b1, 32'h7C7C7C7C});
        directed_rows.push_back('{OP_TIME,   16'hFFFF,  6'h3F, 7'h7F,  1'b1, 32'h7C7C7C7C});
        directed_rows.push_back('{OP_TIME,   16'hA5A5,  6'd9,  7'd7,   1'b0, 32'h0});
        directed_rows.push_back('{OP_TIME,   16'd0,     6'd18, 7'd42,  1'b0, 32'h0});
        directed_rows.push_back('{OP_DIGIT,  16'd0,     6'h3F, 7'h7F,  1'b1, 32'h0000003F});
        directed_rows.push_back('{OP_DIGIT,  16'd9,     6'd0,  7'd0,   1'b1, 32'h0000007C});
        directed_rows.push_back('{OP_DIGIT,  16'd10,    6'd0,  7'd0,   1'b1, 32'h0000007C});
        directed_rows.push_back('{OP_DIGIT,  16'hFFFF,  6'd0,  7'd0,   1'b1, 32'h0000007C});
        directed_rows.push_back('{OP_DIGIT,  16'd4,     6'd3,  7'd33,  1'b0, 32'h0});
        directed_rows.push_back('{OP_CLEAR,  16'hFFFF,  6'h3F, 7'h7F,  1'b1, 32'h00000000});
        directed_rows.push_back('{OP_CLEAR,  16'd0,     6'd0,  7'd0,   1'b1, 32'h00000000});

        repeat (3)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // Directed part, run at the reset brightness.
        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i]);
            sender_gap($urandom_range(0, 2));
        end

        write_brightness(3'd0);
        run_random_phase(70, 1'b1);

        // The receiver holds off while requests keep coming back to back, so
        // the block fills up and has to stall its request side.
        write_brightness(3'd7);
        hold_off_req = 1'b1;
        repeat (24)
        begin
            offer_request(random_request());
        end
        run_random_phase(50, 1'b0);

        write_brightness(3'($urandom_range(1, 6)));
        run_random_phase(70, 1'b1);

        write_brightness(3'd5);
        run_random_phase(70, 1'b1);

        write_brightness(3'd2);
        run_random_phase(60, 1'b1);

        // Let any stray byte show up before the verdict.
        wait_for_drain();
        repeat (20)
        begin
            @(posedge clk);
        end

        if (error_count == 0)
        begin
            $display("four_digit_segment_frame_builder: match");
        end
        else
        begin
            $display("four_digit_segment_frame_builder: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/fdsfb_pkg.sv
rtl/fdsfb_digit_pipe.sv
rtl/four_digit_segment_frame_builder.sv
bench/tb_four_digit_segment_frame_builder.sv
